FILE: rtl/complex_arith_unit_macros.svh
// Assertion helpers used by the top-level RTL.
`ifndef COMPLEX_ARITH_UNIT_MACROS_SVH
`define COMPLEX_ARITH_UNIT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define CAU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define CAU_ASSERT_IMPL(label, ante, cons, msg) \
  `CAU_ASSERT(label, (ante) |-> (cons), msg)

`endif

FILE: rtl/cau_pkg.sv
package cau_pkg;

  localparam int unsigned DataWidth = 16;
  // Exact width of any sum of two full products.
  localparam int unsigned SumWidth  = 2 * DataWidth + 1;

  typedef enum logic [1:0] {
    CmdAdd = 2'd0,
    CmdSub = 2'd1,
    CmdMul = 2'd2,
    CmdDiv = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    StatOk      = 2'd0,
    StatSat     = 2'd1,
    StatDivZero = 2'd2
  } status_e;

  typedef struct packed {
    cmd_e                        command;
    logic signed [DataWidth-1:0] a_re;
    logic signed [DataWidth-1:0] a_im;
    logic signed [DataWidth-1:0] b_re;
    logic signed [DataWidth-1:0] b_im;
  } in_word_t;

  typedef struct packed {
    logic signed [DataWidth-1:0] res_re;
    logic signed [DataWidth-1:0] res_im;
    status_e                     status;
  } out_word_t;

  // One part of a result on its way through the divider.
  typedef struct packed {
    logic signed [SumWidth-1:0] val;  // final value for add, subtract, multiply
    logic                       neg;  // quotient sign
    logic                       ovf;  // quotient too large for DataWidth bits
    logic [DataWidth-1:0]       quo;  // quotient magnitude
  } part_t;

  typedef struct packed {
    cmd_e  cmd;
    logic  dz;
    part_t re;
    part_t im;
  } div_res_t;

endpackage

FILE: rtl/cau_mul.sv
module cau_mul (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     valid_i,
  output logic                                     ready_o,
  input  cau_pkg::in_word_t                        word_i,
  output logic                                     valid_o,
  input  logic                                     ready_i,
  output cau_pkg::cmd_e                            cmd_o,
  output logic signed [cau_pkg::SumWidth-1:0]      num_re_o,
  output logic signed [cau_pkg::SumWidth-1:0]      num_im_o,
  output logic [2*cau_pkg::DataWidth-1:0]          den_o
);

  localparam int unsigned W  = cau_pkg::DataWidth;
  localparam int unsigned PW = 2 * W;
  localparam int unsigned SW = cau_pkg::SumWidth;

  // Stage A: products and add/subtract.
  logic              va_q;
  cau_pkg::cmd_e     cmd_a_q;
  logic signed [PW-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q, p_bb_re_q, p_bb_im_q;
  logic signed [W:0]    as_re_q, as_im_q;

  logic signed [PW-1:0] ar_x, ai_x, br_x, bi_x;
  logic signed [W:0]    as_re_d, as_im_d;
  logic                 en_a, en_b;

  // Stage B: numerators and squared divisor magnitude.
  logic              vb_q;

  assign ar_x = word_i.a_re;
  assign ai_x = word_i.a_im;
  assign br_x = word_i.b_re;
  assign bi_x = word_i.b_im;

  always_comb begin
    if (word_i.command == cau_pkg::CmdSub) begin
      as_re_d = (W+1)'(word_i.a_re) - (W+1)'(word_i.b_re);
      as_im_d = (W+1)'(word_i.a_im) - (W+1)'(word_i.b_im);
    end else begin
      as_re_d = (W+1)'(word_i.a_re) + (W+1)'(word_i.b_re);
      as_im_d = (W+1)'(word_i.a_im) + (W+1)'(word_i.b_im);
    end
  end

  assign en_b    = !vb_q || ready_i;
  assign en_a    = !va_q || en_b;
  assign ready_o = en_a;
  assign valid_o = vb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (en_a) va_q <= valid_i;
      if (en_b) vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a) begin
      cmd_a_q   <= word_i.command;
      p_rr_q    <= ar_x * br_x;
      p_ii_q    <= ai_x * bi_x;
      p_ri_q    <= ar_x * bi_x;
      p_ir_q    <= ai_x * br_x;
      p_bb_re_q <= br_x * br_x;
      p_bb_im_q <= bi_x * bi_x;
      as_re_q   <= as_re_d;
      as_im_q   <= as_im_d;
    end
  end

  logic signed [SW-1:0] num_re_d, num_im_d;

  always_comb begin
    case (cmd_a_q)
      cau_pkg::CmdMul: begin
        num_re_d = SW'(p_rr_q) - SW'(p_ii_q);
        num_im_d = SW'(p_ri_q) + SW'(p_ir_q);
      end
      cau_pkg::CmdDiv: begin
        num_re_d = SW'(p_rr_q) + SW'(p_ii_q);
        num_im_d = SW'(p_ir_q) - SW'(p_ri_q);
      end
      default: begin
        num_re_d = SW'(as_re_q);
        num_im_d = SW'(as_im_q);
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_b) begin
      cmd_o    <= cmd_a_q;
      num_re_o <= num_re_d;
      num_im_o <= num_im_d;
      den_o    <= PW'(p_bb_re_q) + PW'(p_bb_im_q);
    end
  end

endmodule

FILE: rtl/cau_div.sv
module cau_div #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  output logic                                ready_o,
  input  cau_pkg::cmd_e                       cmd_i,
  input  logic signed [cau_pkg::SumWidth-1:0] num_re_i,
  input  logic signed [cau_pkg::SumWidth-1:0] num_im_i,
  input  logic [2*cau_pkg::DataWidth-1:0]     den_i,
  output logic                                valid_o,
  input  logic                                ready_i,
  output cau_pkg::div_res_t                   res_o
);

  localparam int unsigned W  = cau_pkg::DataWidth;
  localparam int unsigned PW = 2 * W;
  localparam int unsigned RW = 3 * W + FRAC_BITS;

  // Stage 0 prepares; stages 1..W each settle one quotient bit, MSB first.
  logic [W:0]        v_q;
  cau_pkg::div_res_t res_q    [0:W];
  logic [RW-1:0]     rem_re_q [0:W-1];
  logic [RW-1:0]     rem_im_q [0:W-1];
  logic [PW-1:0]     den_q    [0:W-1];

  wire  [W+1:0]             en;
  wire cau_pkg::div_res_t   nxt_res [1:W];
  wire [RW-1:0]             nxt_re  [1:W];
  wire [RW-1:0]             nxt_im  [1:W];

  // Prep: magnitudes, scaled dividends and overflow screen.
  logic [PW-1:0]     mag_re, mag_im;
  logic [RW-1:0]     x_re, x_im, den_top;
  cau_pkg::div_res_t prep;

  always_comb begin
    mag_re  = num_re_i[cau_pkg::SumWidth-1] ? PW'(-num_re_i) : PW'(num_re_i);
    mag_im  = num_im_i[cau_pkg::SumWidth-1] ? PW'(-num_im_i) : PW'(num_im_i);
    x_re    = RW'(mag_re) << FRAC_BITS;
    x_im    = RW'(mag_im) << FRAC_BITS;
    den_top = RW'(den_i) << W;
    prep.cmd    = cmd_i;
    prep.dz     = (cmd_i == cau_pkg::CmdDiv) && (den_i == '0);
    prep.re.val = (cmd_i == cau_pkg::CmdMul) ? (num_re_i >>> FRAC_BITS) : num_re_i;
    prep.im.val = (cmd_i == cau_pkg::CmdMul) ? (num_im_i >>> FRAC_BITS) : num_im_i;
    prep.re.neg = num_re_i[cau_pkg::SumWidth-1];
    prep.im.neg = num_im_i[cau_pkg::SumWidth-1];
    prep.re.ovf = x_re >= den_top;
    prep.im.ovf = x_im >= den_top;
    prep.re.quo = '0;
    prep.im.quo = '0;
  end

  assign en[W+1] = ready_i;
  for (genvar s = 0; s <= W; s++) begin : g_en
    assign en[s] = !v_q[s] || en[s+1];
  end

  for (genvar s = 1; s <= W; s++) begin : g_step
    localparam int unsigned Bit = W - s;
    logic [RW-1:0]     dsh;
    logic              ge_re, ge_im;
    cau_pkg::div_res_t loc;

    assign dsh   = RW'(den_q[s-1]) << Bit;
    assign ge_re = rem_re_q[s-1] >= dsh;
    assign ge_im = rem_im_q[s-1] >= dsh;

    always_comb begin
      loc = res_q[s-1];
      loc.re.quo[Bit] = ge_re;
      loc.im.quo[Bit] = ge_im;
    end

    assign nxt_res[s] = loc;
    assign nxt_re[s]  = ge_re ? rem_re_q[s-1] - dsh : rem_re_q[s-1];
    assign nxt_im[s]  = ge_im ? rem_im_q[s-1] - dsh : rem_im_q[s-1];
  end

  assign ready_o = en[0];
  assign valid_o = v_q[W];
  assign res_o   = res_q[W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= valid_i;
      for (int s = 1; s <= W; s++) begin
        if (en[s]) v_q[s] <= v_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      res_q[0]    <= prep;
      rem_re_q[0] <= x_re;
      rem_im_q[0] <= x_im;
      den_q[0]    <= den_i;
    end
    for (int s = 1; s <= W; s++) begin
      if (en[s]) res_q[s] <= nxt_res[s];
    end
    for (int s = 1; s < W; s++) begin
      if (en[s]) begin
        rem_re_q[s] <= nxt_re[s];
        rem_im_q[s] <= nxt_im[s];
        den_q[s]    <= den_q[s-1];
      end
    end
  end

endmodule

FILE: rtl/cau_sat.sv
module cau_sat (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  cau_pkg::div_res_t  res_i,
  output logic               valid_o,
  input  logic               stall_i,
  output cau_pkg::out_word_t word_o
);

  localparam int unsigned W  = cau_pkg::DataWidth;
  localparam int unsigned SW = cau_pkg::SumWidth;
  localparam logic signed [SW-1:0] SatMax = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [SW-1:0] SatMin = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};

  logic                 v_q, en;
  logic signed [SW-1:0] sv_re, sv_im, ext_re, ext_im;
  logic                 hi_re, lo_re, hi_im, lo_im;
  cau_pkg::out_word_t   word_d;

  always_comb begin
    ext_re = $signed({{(SW-W-1){1'b0}}, res_i.re.ovf, res_i.re.quo});
    ext_im = $signed({{(SW-W-1){1'b0}}, res_i.im.ovf, res_i.im.quo});
    if (res_i.cmd == cau_pkg::CmdDiv) begin
      sv_re = res_i.re.neg ? -ext_re : ext_re;
      sv_im = res_i.im.neg ? -ext_im : ext_im;
    end else begin
      sv_re = res_i.re.val;
      sv_im = res_i.im.val;
    end
    hi_re = sv_re > SatMax;
    lo_re = sv_re < SatMin;
    hi_im = sv_im > SatMax;
    lo_im = sv_im < SatMin;

    word_d.res_re = hi_re ? W'(SatMax) : (lo_re ? W'(SatMin) : W'(sv_re));
    word_d.res_im = hi_im ? W'(SatMax) : (lo_im ? W'(SatMin) : W'(sv_im));
    word_d.status = (hi_re || lo_re || hi_im || lo_im) ? cau_pkg::StatSat : cau_pkg::StatOk;
    if (res_i.dz) begin
      word_d.res_re = '0;
      word_d.res_im = '0;
      word_d.status = cau_pkg::StatDivZero;
    end
  end

  assign en      = !v_q || !stall_i;
  assign ready_o = en;
  assign valid_o = v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) word_o <= word_d;
  end

endmodule

FILE: rtl/complex_arith_unit.sv
// Input word to output word passes the multiply stages, divider prep, quotient-bit stages and output register.
// Throughput: one word per cycle unless the output stalls; the restoring divider settles one quotient bit per stage.
// Stalls propagate stage by stage, so empty stages keep filling while the output waits.
// Reset clears only the valid bits of every stage; data registers are not reset.
`include "complex_arith_unit_macros.svh"

module complex_arith_unit #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  cau_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output cau_pkg::out_word_t out_word_o
);

  // Multiply front end -> divider/prep -> saturate and output register.
  logic                                  mul_valid, mul_ready;
  logic                                  in_ready;
  cau_pkg::cmd_e                         mul_cmd;
  logic signed [cau_pkg::SumWidth-1:0]   mul_num_re, mul_num_im;
  logic [2*cau_pkg::DataWidth-1:0]       mul_den;

  logic                                  div_valid, div_ready;
  cau_pkg::div_res_t                     div_res;

  assign in_stall_o = !in_ready;

  // Two stages: partial products, then numerators and squared magnitude.
  cau_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_valid_i),
    .ready_o  (in_ready),
    .word_i   (in_word_i),
    .valid_o  (mul_valid),
    .ready_i  (mul_ready),
    .cmd_o    (mul_cmd),
    .num_re_o (mul_num_re),
    .num_im_o (mul_num_im),
    .den_o    (mul_den)
  );

  // Prep stage plus one stage per quotient bit; other commands ride along.
  cau_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (mul_valid),
    .ready_o  (mul_ready),
    .cmd_i    (mul_cmd),
    .num_re_i (mul_num_re),
    .num_im_i (mul_num_im),
    .den_i    (mul_den),
    .valid_o  (div_valid),
    .ready_i  (div_ready),
    .res_o    (div_res)
  );

  // Final sign, saturation and status; this register holds the word under stall.
  cau_sat u_sat (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (div_valid),
    .ready_o (div_ready),
    .res_i   (div_res),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .word_o  (out_word_o)
  );

  // A divide by zero always returns a zero result.
  `CAU_ASSERT_IMPL(a_dz_zero, out_valid_o && (out_word_o.status == cau_pkg::StatDivZero), (out_word_o.res_re == '0) && (out_word_o.res_im == '0), "divide by zero with nonzero result")
  // Saturated status means at least one part sits at a range limit.
  `CAU_ASSERT_IMPL(a_sat_limit, out_valid_o && (out_word_o.status == cau_pkg::StatSat), (out_word_o.res_re == {1'b0, {(cau_pkg::DataWidth-1){1'b1}}}) || (out_word_o.res_re == {1'b1, {(cau_pkg::DataWidth-1){1'b0}}}) || (out_word_o.res_im == {1'b0, {(cau_pkg::DataWidth-1){1'b1}}}) || (out_word_o.res_im == {1'b1, {(cau_pkg::DataWidth-1){1'b0}}}), "saturated status without limit value")
  // A full front end stalled by the divider must hold its command output steady.
  `CAU_ASSERT_IMPL(a_backpressure, mul_valid && !mul_ready && !in_ready, $past(in_ready) || $stable(mul_cmd), "front end advanced into stalled divider")

endmodule
